// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PFA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfa assertion failed");

// next-cycle implication
`define PFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfa assertion failed");

`endif

// ----- rtl/core/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, codes and sizes shared by the frame allocator modules.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int FRAME_BITS   = 20;
	localparam int PAGE_SHIFT   = 12;
	localparam int ADDR_BITS    = 32;
	localparam int KIND_BITS    = 3;

	localparam int REGION_SLOTS = 16;
	localparam int RIDX_W       = $clog2(REGION_SLOTS);
	localparam int RCNT_W       = $clog2(REGION_SLOTS + 1);

	localparam int STACK_DEPTH  = 1024;
	localparam int SADDR_W      = $clog2(STACK_DEPTH);
	localparam int SCNT_W       = $clog2(STACK_DEPTH + 1);

	// command queue and result queue depth
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W    = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_FIRST = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_END   = 1'd1;

	localparam logic [FRAME_BITS-1:0] RES_FIRST_RST = 20'd256;
	localparam logic [FRAME_BITS-1:0] RES_END_RST   = 20'd512;

	localparam logic [KIND_BITS-1:0] KIND_END   = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_AVAIL = 3'd1;

	localparam logic [ADDR_BITS:0] PAGE_OFFSET = 33'h0_0000_0FFF;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_RESTART = 2'd1,
		ACT_ALLOC   = 2'd2,
		ACT_FREE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_OUT        = 2'd1,
		ST_STACK_FULL = 2'd2,
		ST_TABLE_FULL = 2'd3
	} result_code_t;

	typedef struct packed {
		action_t                action;
		logic [ADDR_BITS-1:0]   region_base;
		logic [ADDR_BITS-1:0]   region_bytes;
		logic [KIND_BITS-1:0]   region_type;
		logic [FRAME_BITS-1:0]  freed_frame;
	} req_t;

	typedef struct packed {
		result_code_t           status;
		logic [FRAME_BITS-1:0]  granted_frame;
	} rsp_t;

	// decoded command passed from front to executor
	typedef struct packed {
		action_t                action;
		logic [FRAME_BITS-1:0]  start_frame;
		logic [FRAME_BITS-1:0]  pages;
		logic [KIND_BITS-1:0]   kind;
		logic [FRAME_BITS-1:0]  freed_frame;
	} cmd_t;

endpackage

// ----- rtl/core/pfa_front.sv -----
// ----------------------------------------------------------------------------
// pfa_front
// Accepts requests, turns region loads into frame terms and queues commands.
// ----------------------------------------------------------------------------
module pfa_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  pfa_pkg::req_t req,
	output logic         cmd_valid,
	input  logic         cmd_pop,
	output pfa_pkg::cmd_t cmd
);
	import pfa_pkg::*;

	cmd_t              q_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              wr_en;
	logic              rd_en;
	logic [ADDR_BITS:0] base_up;
	cmd_t              cmd_new;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = q_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	// align base up to a page, count whole pages only
	assign base_up = {1'b0, req.region_base} + PAGE_OFFSET;

	always_comb begin
		cmd_new.action      = req.action;
		cmd_new.start_frame = base_up[PAGE_SHIFT +: FRAME_BITS];
		cmd_new.pages       = req.region_bytes[PAGE_SHIFT +: FRAME_BITS];
		cmd_new.kind        = req.region_type;
		cmd_new.freed_frame = req.freed_frame;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/pfa_back.sv -----
// ----------------------------------------------------------------------------
// pfa_back
// Executes commands: region table, map cursor walk, free stack, result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfa_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_pop,
	input  pfa_pkg::cmd_t                      cmd,
	input  logic                               cfg_we,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfa_pkg::FRAME_BITS-1:0]     cfg_data,
	output logic                               empty,
	input  logic                               pop,
	output pfa_pkg::rsp_t                      rsp
);
	import pfa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_WALK,
		S_ENTER
	} state_t;

	state_t                state_q, state_d;

	logic [FRAME_BITS-1:0] res_first_q;
	logic [FRAME_BITS-1:0] res_end_q;

	logic [FRAME_BITS-1:0] start_q [REGION_SLOTS];
	logic [FRAME_BITS-1:0] pages_tbl_q [REGION_SLOTS];
	logic [KIND_BITS-1:0]  kind_q [REGION_SLOTS];
	logic                  tbl_we;

	logic [RCNT_W-1:0]     total_q, total_d;
	logic [RCNT_W-1:0]     cur_region_q, cur_region_d;
	logic [FRAME_BITS-1:0] cur_frame_q, cur_frame_d;
	logic [FRAME_BITS-1:0] cur_pages_q, cur_pages_d;
	logic                  exhausted_q, exhausted_d;

	logic [FRAME_BITS-1:0] stack_mem [STACK_DEPTH];
	logic [SCNT_W-1:0]     top_q, top_d;
	logic [FRAME_BITS-1:0] stk_rd_q;
	logic                  mem_we;
	logic                  mem_re;

	rsp_t                  res_q [QDEPTH];
	logic [QPTR_W-1:0]     res_wr_q;
	logic [QPTR_W-1:0]     res_rd_q;
	logic [QCNT_W-1:0]     res_count_q;
	logic                  res_push;
	logic                  res_pop;
	rsp_t                  res_item;

	logic [RIDX_W-1:0]     cur_idx;
	logic [KIND_BITS-1:0]  cur_kind;
	logic                  in_window;
	logic [FRAME_BITS-1:0] skip_full;
	logic [FRAME_BITS-1:0] skip;

	assign cur_idx   = cur_region_q[RIDX_W-1:0];
	assign cur_kind  = kind_q[cur_idx];
	assign in_window = (cur_frame_q >= res_first_q) && (cur_frame_q < res_end_q);
	assign skip_full = res_end_q - cur_frame_q;
	assign skip      = (skip_full > cur_pages_q) ? cur_pages_q : skip_full;

	assign empty   = (res_count_q == '0);
	assign rsp     = res_q[res_rd_q];
	assign res_pop = pop && !empty;

	always_comb begin
		state_d      = state_q;
		total_d      = total_q;
		cur_region_d = cur_region_q;
		cur_frame_d  = cur_frame_q;
		cur_pages_d  = cur_pages_q;
		exhausted_d  = exhausted_q;
		top_d        = top_q;
		cmd_pop      = 1'b0;
		tbl_we       = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		res_push     = 1'b0;
		res_item     = '{status: ST_OK, granted_frame: '0};

		unique case (state_q)
			S_IDLE: begin
				// one command in flight, so a free result slot at start is enough
				if (cmd_valid && (res_count_q != QCNT_W'(QDEPTH))) begin
					cmd_pop = 1'b1;
					unique case (cmd.action)
						ACT_LOAD: begin
							res_push = 1'b1;
							if (total_q == RCNT_W'(REGION_SLOTS)) begin
								res_item.status = ST_TABLE_FULL;
							end else begin
								tbl_we  = 1'b1;
								total_d = total_q + RCNT_W'(1);
								// cursor waiting on this slot picks it up now
								if (!exhausted_q && (cur_region_q == total_q)) begin
									cur_frame_d = cmd.start_frame;
									cur_pages_d = cmd.pages;
								end
							end
						end
						ACT_RESTART: begin
							res_push     = 1'b1;
							exhausted_d  = 1'b0;
							cur_region_d = '0;
							if (total_q != '0) begin
								cur_frame_d = start_q[0];
								cur_pages_d = pages_tbl_q[0];
							end else begin
								cur_frame_d = '0;
								cur_pages_d = '0;
							end
						end
						ACT_ALLOC: begin
							if (top_q != '0) begin
								top_d   = top_q - SCNT_W'(1);
								mem_re  = 1'b1;
								state_d = S_POP;
							end else begin
								state_d = S_WALK;
							end
						end
						ACT_FREE: begin
							res_push = 1'b1;
							if (top_q == SCNT_W'(STACK_DEPTH)) begin
								res_item.status = ST_STACK_FULL;
							end else begin
								mem_we = 1'b1;
								top_d  = top_q + SCNT_W'(1);
							end
						end
						default: ;
					endcase
				end
			end
			S_POP: begin
				res_push               = 1'b1;
				res_item.granted_frame = stk_rd_q;
				state_d                = S_IDLE;
			end
			S_WALK: begin
				priority if (exhausted_q) begin
					res_push        = 1'b1;
					res_item.status = ST_OUT;
					state_d         = S_IDLE;
				end else if ((cur_region_q >= total_q) || (cur_kind == KIND_END)) begin
					exhausted_d     = 1'b1;
					res_push        = 1'b1;
					res_item.status = ST_OUT;
					state_d         = S_IDLE;
				end else if ((cur_kind != KIND_AVAIL) || (cur_pages_q == '0)) begin
					cur_region_d = cur_region_q + RCNT_W'(1);
					state_d      = S_ENTER;
				end else if (in_window) begin
					// jump over the reserved window, clipped to the region
					cur_frame_d = cur_frame_q + skip;
					cur_pages_d = cur_pages_q - skip;
				end else begin
					res_push               = 1'b1;
					res_item.granted_frame = cur_frame_q;
					cur_frame_d            = cur_frame_q + FRAME_BITS'(1);
					cur_pages_d            = cur_pages_q - FRAME_BITS'(1);
					state_d                = S_IDLE;
				end
			end
			S_ENTER: begin
				if (cur_region_q >= total_q) begin
					exhausted_d     = 1'b1;
					cur_frame_d     = '0;
					cur_pages_d     = '0;
					res_push        = 1'b1;
					res_item.status = ST_OUT;
					state_d         = S_IDLE;
				end else begin
					cur_frame_d = start_q[cur_idx];
					cur_pages_d = pages_tbl_q[cur_idx];
					state_d     = S_WALK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			total_q      <= '0;
			cur_region_q <= '0;
			cur_frame_q  <= '0;
			cur_pages_q  <= '0;
			exhausted_q  <= 1'b0;
			top_q        <= '0;
		end else begin
			state_q      <= state_d;
			total_q      <= total_d;
			cur_region_q <= cur_region_d;
			cur_frame_q  <= cur_frame_d;
			cur_pages_q  <= cur_pages_d;
			exhausted_q  <= exhausted_d;
			top_q        <= top_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_first_q <= RES_FIRST_RST;
			res_end_q   <= RES_END_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RES_FIRST: res_first_q <= cfg_data;
				CFG_RES_END:   res_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			start_q[total_q[RIDX_W-1:0]]     <= cmd.start_frame;
			pages_tbl_q[total_q[RIDX_W-1:0]] <= cmd.pages;
			kind_q[total_q[RIDX_W-1:0]]      <= cmd.kind;
		end
	end

	// free stack memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[top_q[SADDR_W-1:0]] <= cmd.freed_frame;
		end
		if (mem_re) begin
			stk_rd_q <= stack_mem[top_d[SADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q    <= '0;
			res_rd_q    <= '0;
			res_count_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= (res_wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : res_wr_q + QPTR_W'(1);
			end
			if (res_pop) begin
				res_rd_q <= (res_rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : res_rd_q + QPTR_W'(1);
			end
			if (res_push && !res_pop) begin
				res_count_q <= res_count_q + QCNT_W'(1);
			end else if (res_pop && !res_push) begin
				res_count_q <= res_count_q - QCNT_W'(1);
			end
		end
	end

	`PFA_ASSERT_IMP(a_cursor_in_table, 1'b1, cur_region_q <= total_q)
	`PFA_ASSERT_IMP(a_res_no_overflow, res_push, (res_count_q != QCNT_W'(QDEPTH)) || res_pop)
	`PFA_ASSERT_NEXT(a_pop_after_read, mem_re, state_q == S_POP)
	`PFA_ASSERT_IMP(a_grant_has_pages,
		(state_q == S_WALK) && res_push && (res_item.status == ST_OK), cur_pages_q != '0)

endmodule

// ----- rtl/core/physical_frame_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// physical_frame_allocator_unit
// 4 KiB frame allocator: region table walk plus a free-frame stack.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   push / full            req (action, region, freed frame)
//  result    empty / pop            rsp (status, granted frame)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data (reserved window)
//
//  the result beat is written: load, restart and free directly from idle; allocate
//  from the stack after the stack memory read port (S_POP); allocate from the map
//  in S_WALK, after an S_ENTER per region skipped and a step per reserved-window jump.
//  reset needs no clearing pass; tables and stack are only read below their fill.
//  full rises when two commands wait; the executor holds while two results wait.
// ----------------------------------------------------------------------------
module physical_frame_allocator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  pfa_pkg::req_t                  req,
	output logic                           empty,
	input  logic                           pop,
	output pfa_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfa_pkg::FRAME_BITS-1:0] cfg_data
);
	import pfa_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	pfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	pfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule

// ----- tb/sv/physical_frame_allocator_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// physical_frame_allocator_unit_checker
// Watches the request, result and register channels of the frame allocator,
// keeps its own copy of the region table, cursor and free stack, predicts
// each answer and compares it with the result popped from the block.
// ----------------------------------------------------------------------------
module physical_frame_allocator_unit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  pfa_pkg::req_t                  req,
	input  logic                           empty,
	input  logic                           pop,
	input  pfa_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfa_pkg::FRAME_BITS-1:0] cfg_data,
	output int                             mismatches,
	output int                             answers_due
);
	import pfa_pkg::*;

	logic [FRAME_BITS-1:0] window_lo;
	logic [FRAME_BITS-1:0] window_hi;

	logic [FRAME_BITS-1:0] region_frame [REGION_SLOTS];
	logic [FRAME_BITS-1:0] region_pages [REGION_SLOTS];
	logic [KIND_BITS-1:0]  region_kind  [REGION_SLOTS];
	int                    regions_loaded;

	int                    walk_region;
	logic [FRAME_BITS-1:0] walk_frame;
	logic [FRAME_BITS-1:0] walk_left;
	bit                    map_spent;

	logic [FRAME_BITS-1:0] freed_stack [STACK_DEPTH];
	int                    freed_depth;

	rsp_t                  awaited_answers [$];
	rsp_t                  oldest_answer;
	int                    fail_total;

	function automatic void seek_region(int idx);
		if (idx < regions_loaded) begin
			walk_region = idx;
			walk_frame  = region_frame[idx];
			walk_left   = region_pages[idx];
		end else begin
			walk_region = regions_loaded;
			walk_frame  = '0;
			walk_left   = '0;
		end
	endfunction

	function automatic void walk_map(output bit got, output logic [FRAME_BITS-1:0] frame);
		logic [FRAME_BITS-1:0] skip;
		bit                    stop;
		got   = 1'b0;
		frame = '0;
		stop  = 1'b0;
		while (!stop) begin
			if (map_spent) begin
				stop = 1'b1;
			end else if (walk_region >= regions_loaded ||
					region_kind[walk_region] == KIND_END) begin
				map_spent = 1'b1;
				stop      = 1'b1;
			end else if (region_kind[walk_region] != KIND_AVAIL || walk_left == 0) begin
				seek_region(walk_region + 1);
			end else if (walk_frame >= window_lo && walk_frame < window_hi) begin
				// jump over the reserved window, but not past the region
				skip = window_hi - walk_frame;
				if (skip > walk_left)
					skip = walk_left;
				walk_frame = walk_frame + skip;
				walk_left  = walk_left - skip;
			end else begin
				frame      = walk_frame;
				walk_frame = walk_frame + 1'b1;
				walk_left  = walk_left - 1'b1;
				got        = 1'b1;
				stop       = 1'b1;
			end
		end
	endfunction

	function automatic rsp_t predict_answer(req_t r);
		rsp_t                  a;
		logic [ADDR_BITS:0]    rounded;
		logic [FRAME_BITS-1:0] frame;
		bit                    got;
		a.status        = ST_OK;
		a.granted_frame = '0;
		case (r.action)
			ACT_LOAD: begin
				if (regions_loaded >= REGION_SLOTS) begin
					a.status = ST_TABLE_FULL;
				end else begin
					rounded = {1'b0, r.region_base} + PAGE_OFFSET;
					region_frame[regions_loaded] = rounded[PAGE_SHIFT +: FRAME_BITS];
					region_pages[regions_loaded] = r.region_bytes[PAGE_SHIFT +: FRAME_BITS];
					region_kind[regions_loaded]  = r.region_type;
					regions_loaded++;
					// cursor parked on this slot picks the new region up at once
					if (!map_spent && walk_region == regions_loaded - 1)
						seek_region(walk_region);
				end
			end
			ACT_RESTART: begin
				map_spent = 1'b0;
				seek_region(0);
			end
			ACT_ALLOC: begin
				if (freed_depth > 0) begin
					freed_depth--;
					a.granted_frame = freed_stack[freed_depth];
				end else begin
					walk_map(got, frame);
					if (got)
						a.granted_frame = frame;
					else
						a.status = ST_OUT;
				end
			end
			ACT_FREE: begin
				if (freed_depth >= STACK_DEPTH) begin
					a.status = ST_STACK_FULL;
				end else begin
					freed_stack[freed_depth] = r.freed_frame;
					freed_depth++;
				end
			end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_lo      = RES_FIRST_RST;
			window_hi      = RES_END_RST;
			regions_loaded = 0;
			walk_region    = 0;
			walk_frame     = '0;
			walk_left      = '0;
			map_spent      = 1'b0;
			freed_depth    = 0;
			fail_total     = 0;
			awaited_answers.delete();
			mismatches  <= 0;
			answers_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_RES_FIRST)
					window_lo = cfg_data;
				else if (cfg_index == CFG_RES_END)
					window_hi = cfg_data;
			end
			// results popped now belong to requests taken at earlier edges
			if (pop && !empty) begin
				if (awaited_answers.size() == 0) begin
					if (fail_total < 10)
						$display("[%0t] result beat with no request pending: status %0d frame 0x%05h",
							$time, rsp.status, rsp.granted_frame);
					fail_total++;
				end else begin
					oldest_answer = awaited_answers.pop_front();
					if (rsp.status !== oldest_answer.status ||
							rsp.granted_frame !== oldest_answer.granted_frame) begin
						if (fail_total < 10)
							$display({"[%0t] answer mismatch: expected status %0d frame 0x%05h,",
								" got status %0d frame 0x%05h"}, $time,
								oldest_answer.status, oldest_answer.granted_frame,
								rsp.status, rsp.granted_frame);
						fail_total++;
					end
				end
			end
			if (push && !full)
				awaited_answers.push_back(predict_answer(req));
			mismatches  <= fail_total;
			answers_due <= awaited_answers.size();
		end
	end

endmodule

// ----- tb/sv/physical_frame_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// physical_frame_allocator_unit_tb
// Builds a small memory map, then runs phases of random allocate, free,
// restart and load requests under several reserved windows, with random
// stalls on both queues; the checker beside the block scores every answer.
// ----------------------------------------------------------------------------
module physical_frame_allocator_unit_tb;
	import pfa_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int PHASES         = 8;

	// unusable region kinds
	localparam logic [KIND_BITS-1:0] KIND_RESERVED = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_RECLAIM  = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_NVS      = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_BAD      = 3'd5;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	req_t                  req;
	logic                  empty;
	logic                  pop;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [FRAME_BITS-1:0] cfg_data;

	int mismatches;
	int answers_due;

	bit sender_idles;
	bit receiver_idles;
	bit hold_request;

	// reserved windows per phase: all but the top frame, inverted, empty,
	// frame zero only, inside a region, one frame, the wrap region, reset values
	logic [FRAME_BITS-1:0] window_lo_set [PHASES] = '{20'h00000, 20'hFFFFF, 20'h00005,
		20'h00000, 20'h12346, 20'h00001, 20'hFFFFE, 20'h00100};
	logic [FRAME_BITS-1:0] window_hi_set [PHASES] = '{20'hFFFFF, 20'h00000, 20'h00005,
		20'h00001, 20'h1234A, 20'h00002, 20'hFFFFF, 20'h00200};

	physical_frame_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	physical_frame_allocator_unit_checker answer_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req         (req),
		.empty       (empty),
		.pop         (pop),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.answers_due (answers_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic req_t make_request(action_t a, logic [ADDR_BITS-1:0] base,
			logic [ADDR_BITS-1:0] bytes, logic [KIND_BITS-1:0] kind,
			logic [FRAME_BITS-1:0] freed);
		req_t r;
		r.action       = a;
		r.region_base  = base;
		r.region_bytes = bytes;
		r.region_type  = kind;
		r.freed_frame  = freed;
		return r;
	endfunction

	function automatic req_t random_request(int alloc_w, int free_w, int restart_w, int load_w);
		req_t r;
		int   pick;
		r.region_base  = $urandom();
		r.region_bytes = $urandom();
		r.region_type  = KIND_BITS'($urandom_range(0, 5));
		r.freed_frame  = FRAME_BITS'($urandom_range(0, 20'hFFFFF));
		pick = $urandom_range(1, alloc_w + free_w + restart_w + load_w);
		if (pick <= alloc_w)
			r.action = ACT_ALLOC;
		else if (pick <= alloc_w + free_w)
			r.action = ACT_FREE;
		else if (pick <= alloc_w + free_w + restart_w)
			r.action = ACT_RESTART;
		else
			r.action = ACT_LOAD;
		return r;
	endfunction

	task automatic offer_request(req_t r);
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full);
		if (sender_idles && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// stop sending and let every outstanding answer come back
	task automatic settle_results();
		push <= 1'b0;
		@(posedge clk);
		while (answers_due != 0) @(posedge clk);
	endtask

	task automatic set_reserved_window(logic [FRAME_BITS-1:0] lo, logic [FRAME_BITS-1:0] hi);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_RES_FIRST;
		cfg_data  <= lo;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_RES_END;
		cfg_data  <= hi;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stall bursts, plus one long hold on request
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (receiver_idles && $urandom_range(0, 11) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int i;
		int ph;
		arst_n         <= 1'b0;
		push           <= 1'b0;
		req            <= '0;
		cfg_valid      <= 1'b0;
		cfg_index      <= CFG_RES_FIRST;
		cfg_data       <= '0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		hold_request   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: restart, run off the end, stack round trip
		offer_request(make_request(ACT_RESTART, '0, '0, KIND_END, '0));
		offer_request(make_request(ACT_ALLOC, '0, '0, KIND_END, '0));
		offer_request(make_request(ACT_FREE, '1, '1, KIND_BAD, 20'hFFFFF));
		offer_request(make_request(ACT_ALLOC, '0, '0, KIND_END, '0));
		offer_request(make_request(ACT_RESTART, '0, '0, KIND_END, '0));
		// first load lands on the slot the cursor waits on
		offer_request(make_request(ACT_LOAD, 32'h0000_0000, 32'h0000_3000, KIND_AVAIL, '0));
		offer_request(make_request(ACT_ALLOC, '0, '0, KIND_END, '0));
		// unaligned base, all pages inside the reserved window
		offer_request(make_request(ACT_LOAD, 32'h000F_F001, 32'h0000_5FFF, KIND_AVAIL, '0));
		// base rounds up past the frame width
		offer_request(make_request(ACT_LOAD, 32'hFFFF_F001, 32'h0000_2FFF, KIND_AVAIL, '0));
		offer_request(make_request(ACT_LOAD, 32'hAAAA_A000, 32'hFFFF_FFFF, KIND_RESERVED, '0));
		// shorter than a page
		offer_request(make_request(ACT_LOAD, 32'h0070_0000, 32'h0000_0FFF, KIND_AVAIL, '0));
		// frame counter wraps inside this one
		offer_request(make_request(ACT_LOAD, 32'hFFFF_E000, 32'h0000_4000, KIND_AVAIL, '0));
		// runs into the reserved window
		offer_request(make_request(ACT_LOAD, 32'h000F_C000, 32'h0000_A000, KIND_AVAIL, '0));
		offer_request(make_request(ACT_LOAD, 32'h0800_0000, 32'h0010_0000, KIND_RECLAIM, '0));
		offer_request(make_request(ACT_LOAD, 32'h0900_0000, 32'h0010_0000, KIND_NVS, '0));
		offer_request(make_request(ACT_LOAD, 32'h0A00_0000, 32'h0010_0000, KIND_BAD, '0));
		offer_request(make_request(ACT_LOAD, 32'h5555_5000, 32'h0000_8000, KIND_AVAIL, '0));
		offer_request(make_request(ACT_LOAD, 32'h1234_5678, 32'h0001_0000, KIND_AVAIL, '0));
		offer_request(make_request(ACT_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_END, '0));
		repeat (3) offer_request(make_request(ACT_ALLOC, '0, '0, KIND_END, '0));
		offer_request(make_request(ACT_FREE, '0, '0, KIND_END, 20'h00000));
		offer_request(make_request(ACT_ALLOC, '0, '0, KIND_END, '0));

		for (ph = 0; ph < PHASES; ph++) begin
			settle_results();
			set_reserved_window(window_lo_set[ph], window_hi_set[ph]);
			sender_idles   = (ph % 3 != 2);
			receiver_idles = (ph % 2 == 0);
			if (ph == 3) begin
				// stack up freed frames while results back up, then hand them out
				hold_request = 1'b1;
				for (i = 0; i < 60; i++)
					offer_request(random_request(0, 1, 0, 0));
				for (i = 0; i < 90; i++)
					offer_request(random_request(90, 5, 5, 0));
			end else begin
				for (i = 0; i < 75; i++)
					offer_request(random_request(50, 22, 15, 13));
			end
		end

		// closing stretch with no stalls on either side
		settle_results();
		set_reserved_window(FRAME_BITS'($urandom_range(0, 1023)),
			FRAME_BITS'($urandom_range(0, 1023)));
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		for (i = 0; i < 100; i++)
			offer_request(random_request(50, 22, 15, 13));
		settle_results();
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
